FILE: rtl/qphi_pkg.sv
// ----------------------------------------------------------------------------
// qphi_pkg: shared types and constants for the quadratic probe hash insert
// Widths of keys, slots and table sizes, the sequencer states and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package qphi_pkg;

  // Table capacity and field widths
  localparam int MAX_SLOTS = 16384;
  localparam int SLOT_W    = 14;           // slot index, values below MAX_SLOTS
  localparam int SIZE_W    = 15;           // table size, values up to MAX_SLOTS
  localparam int KEY_W     = 31;
  localparam int ENTRY_W   = KEY_W + 1;    // used mark on top of the stored key
  localparam int PROBE_W   = SIZE_W + 1;   // probe counter, reaches 2*MAX_SLOTS
  localparam int BIT_W     = 5;            // index into the key bits
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // Clamp limits for the table size register
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SLOTS);
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(11);

  // Register index, taken from paddr[2]
  localparam logic REG_TABLE_SIZE = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_STEP,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/qphi_ram.sv
// ----------------------------------------------------------------------------
// qphi_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qphi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/qphi_addmod.sv
// ----------------------------------------------------------------------------
// qphi_addmod: shared add and reduce unit
// Returns (x + y) mod n for x + y below 2*n, using one add and one
// compare-subtract. Serves the remainder steps and the probe updates.
// ----------------------------------------------------------------------------
module qphi_addmod
  import qphi_pkg::*;
(
  input  logic [SIZE_W-1:0] x,
  input  logic [SIZE_W-1:0] y,
  input  logic [SIZE_W-1:0] n,
  output logic [SLOT_W-1:0] r
);

  logic [SIZE_W:0] sum;
  logic [SIZE_W:0] diff;

  // Add, then subtract n once if the sum reached it
  always_comb begin
    sum  = {1'b0, x} + {1'b0, y};
    diff = sum - {1'b0, n};
    if (sum >= {1'b0, n}) begin
      r = diff[SLOT_W-1:0];
    end else begin
      r = sum[SLOT_W-1:0];
    end
  end

endmodule

FILE: rtl/quadratic_probe_hash_insert.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_insert: open-addressed hash insert, quadratic probing
// Flow: an accepted key runs through a bit-serial remainder (31 steps) in MOD,
//   then READ, CHECK and STEP on the table RAM per probe until a free or matching
//   slot settles it or 2*size probes are spent; FINISH loads the output once free.
// One item at a time: no key is taken until the last result is loaded.
// Reset: synchronous; afterwards a clearing pass over all 16384 slots wipes the
//   table, and no item is taken until it ends. Table size resets to 11.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_insert
  import qphi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Input item
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KEY_W-1:0]  key,
  // Result item
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] slot,
  output logic              placed,
  output logic              already_present,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  state_t state;
  state_t state_next;

  logic [SIZE_W-1:0]  table_size;
  logic [SIZE_W-1:0]  n_eff;
  logic [KEY_W-1:0]   key_r;
  logic [BIT_W-1:0]   bit_idx;
  logic [SLOT_W-1:0]  pos;
  logic [SLOT_W-1:0]  d;
  logic [PROBE_W-1:0] probe;
  logic [SLOT_W-1:0]  clr_addr;

  logic [SLOT_W-1:0]  res_slot;
  logic               res_placed;
  logic               res_present;

  logic [SIZE_W-1:0]  ax;
  logic [SIZE_W-1:0]  ay;
  logic [SLOT_W-1:0]  ar;

  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               rd_used;
  logic               hit_free;
  logic               hit_match;
  logic               at_limit;
  logic               out_load;
  logic               cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_TABLE_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RST;
    end else if (cfg_wr) begin
      table_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TABLE_SIZE) begin
      prdata = {{(DATA_W-SIZE_W){1'b0}}, table_size};
    end
  end

  // Clamp the size to the usable range
  always_comb begin
    if (table_size < SIZE_MIN) begin
      n_eff = SIZE_MIN;
    end else if (table_size > SIZE_MAX) begin
      n_eff = SIZE_MAX;
    end else begin
      n_eff = table_size;
    end
  end

  // Shared add/reduce unit operands
  always_comb begin
    ax = {1'b0, d};
    ay = SIZE_W'(2);
    case (state)
      ST_MOD: begin
        ax = {1'b0, pos};
        ay = {1'b0, pos} + {{(SIZE_W-1){1'b0}}, key_r[bit_idx]};
      end
      ST_STEP: begin
        ax = {1'b0, pos};
        ay = {1'b0, d};
      end
      default: begin
        ax = {1'b0, d};
        ay = SIZE_W'(2);
      end
    endcase
  end

  qphi_addmod u_addmod (
    .x (ax),
    .y (ay),
    .n (n_eff),
    .r (ar)
  );

  // Table RAM: used mark and key per slot
  assign rd_used   = mem_rdata[ENTRY_W-1];
  assign hit_free  = !rd_used;
  assign hit_match = rd_used && (mem_rdata[KEY_W-1:0] == key_r);
  assign at_limit  = probe >= {n_eff, 1'b0};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = {1'b1, key_r};
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == ST_CHECK && hit_free) begin
      mem_we = 1'b1;
    end
  end

  qphi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (pos),
    .rdata (mem_rdata)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == SLOT_W'(MAX_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (bit_idx == '0) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit_free || hit_match || at_limit) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = ST_READ;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  // Datapath: remainder, probe position, step and count
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        key_r   <= key;
        pos     <= '0;
        bit_idx <= BIT_W'(KEY_W - 1);
      end
      ST_MOD: begin
        pos     <= ar;
        bit_idx <= bit_idx - BIT_W'(1);
        // Start the odd step at n-1 (two below 1, mod n) so the first READ brings it to 1
        d       <= SLOT_W'(n_eff - SIZE_W'(1));
        probe   <= PROBE_W'(1);
      end
      ST_READ: begin
        d <= ar;
      end
      ST_STEP: begin
        pos   <= ar;
        probe <= probe + PROBE_W'(1);
      end
      ST_CHECK: begin
        if (hit_free || hit_match) begin
          res_slot    <= pos;
          res_placed  <= 1'b1;
          res_present <= hit_match;
        end else begin
          res_slot    <= '0;
          res_placed  <= 1'b0;
          res_present <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot            <= res_slot;
      placed          <= res_placed;
      already_present <= res_present;
    end
  end

endmodule

FILE: rtl/qphi_checker.sv
// ----------------------------------------------------------------------------
// qphi_checker: port-level checks for the hash insert block
// Watches the item channels and reports violations of the block's
// sequencing and result encoding.
// ----------------------------------------------------------------------------
module qphi_checker
  import qphi_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] slot,
  input logic              placed,
  input logic              already_present
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(placed)
      && $stable(already_present))
    else $error("result changed while stalled");

  // A failed insert reports slot zero and no match
  a_fail_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !placed |-> slot == '0 && !already_present)
    else $error("failed insert carries slot or match flag");

  // Drop ready once an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // Clearing after reset: no item taken, no result shown
  a_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !in_ready && !out_valid)
    else $error("block active right after reset");

endmodule

bind quadratic_probe_hash_insert qphi_checker u_qphi_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .slot            (slot),
  .placed          (placed),
  .already_present (already_present)
);

FILE: dv/hash_insert_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_insert_checker: result checker for the quadratic probe hash insert
// Watches the key, result and configuration channels, keeps its own copy of
// the slot table and the table size register, works out the outcome of
// every accepted key and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module hash_insert_checker
  import qphi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [KEY_W-1:0]  key,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [SLOT_W-1:0] slot,
  input  logic              placed,
  input  logic              already_present,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                inserts_in_flight,
  output int                fault_count
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              placed;
    logic              already_present;
  } insert_outcome_t;

  // Mirror of the register and of the slot table
  logic [SIZE_W-1:0] size_mirror = SIZE_RST;
  bit                used_mirror [MAX_SLOTS];
  logic [KEY_W-1:0]  key_mirror  [MAX_SLOTS];
  insert_outcome_t   outcome_q   [$];
  int                faults = 0;

  // Clamp the register to the range of slots the table can use
  function automatic longint unsigned live_size();
    if (size_mirror < 2) return 2;
    if (size_mirror > MAX_SLOTS) return MAX_SLOTS;
    return size_mirror;
  endfunction

  // Probe home + i*i until a free slot or the same key turns up; claim it
  function automatic insert_outcome_t probe_insert(input logic [KEY_W-1:0] k);
    insert_outcome_t   res;
    longint unsigned   n;
    longint unsigned   home;
    longint unsigned   pos;
    longint unsigned   step;
    res  = '0;
    n    = live_size();
    home = k % n;
    pos  = home;
    step = 1;
    while (used_mirror[pos] && key_mirror[pos] != k) begin
      // probe limit reached: report failure and leave the table alone
      if (step >= 2 * n) return res;
      pos  = (home + step * step) % n;
      step++;
    end
    res.slot   = pos[SLOT_W-1:0];
    res.placed = 1'b1;
    if (used_mirror[pos]) begin
      res.already_present = 1'b1;
    end else begin
      used_mirror[pos] = 1'b1;
      key_mirror[pos]  = k;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    insert_outcome_t want;
    if (rst) begin
      size_mirror = SIZE_RST;
      foreach (used_mirror[i]) used_mirror[i] = 1'b0;
      outcome_q.delete();
    end else begin
      // Track register writes, check register reads
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_TABLE_SIZE) begin
        if (pwrite) begin
          size_mirror = pwdata[SIZE_W-1:0];
        end else if (prdata !== DATA_W'(size_mirror)) begin
          $error("table_size: expected %0d, got %0d", size_mirror, prdata);
          faults++;
        end
      end
      // Compare a taken result with the oldest outstanding insert
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result with no insert waiting: slot %0d placed %0b present %0b",
                 slot, placed, already_present);
          faults++;
        end else begin
          want = outcome_q.pop_front();
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            faults++;
          end
          if (placed !== want.placed) begin
            $error("placed: expected %0b, got %0b", want.placed, placed);
            faults++;
          end
          if (already_present !== want.already_present) begin
            $error("already_present: expected %0b, got %0b",
                   want.already_present, already_present);
            faults++;
          end
        end
      end
      // Work out the outcome of each accepted key
      if (in_valid && in_ready) outcome_q.push_back(probe_insert(key));
    end
    inserts_in_flight <= outcome_q.size();
    fault_count       <= faults;
  end

endmodule

FILE: dv/tb_quadratic_probe_hash_insert.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadratic_probe_hash_insert: testbench for the quadratic probe hash insert
// Feeds keys through a directed part (key extremes, repeats, collisions,
// probe limit failures, clamped table sizes, unmapped register write) and
// then random phases at many table sizes, with random gaps and stalls on
// both channels. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_hash_insert;
  import qphi_pkg::*;

  localparam logic [KEY_W-1:0]  KEY_ALL_ONES    = '1;
  localparam logic [ADDR_W-1:0] ADDR_TABLE_SIZE = {REG_TABLE_SIZE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED   = {~REG_TABLE_SIZE, 2'b00};
  localparam int RANDOM_ITEMS = 730;
  localparam int HOLD_AFTER   = 60;   // accepted keys before the long result hold
  localparam int HOLD_CYCLES  = 400;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [KEY_W-1:0]  key;
  logic              out_valid;
  logic              out_ready;
  logic [SLOT_W-1:0] slot;
  logic              placed;
  logic              already_present;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                inserts_in_flight;
  int                fault_count;

  logic [KEY_W-1:0]  key_pool [$];
  bit                feed_calm;

  quadratic_probe_hash_insert u_dut (
    .clk, .rst,
    .in_valid, .in_ready, .key,
    .out_valid, .out_ready, .slot, .placed, .already_present,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hash_insert_checker u_checker (
    .clk, .rst,
    .in_valid, .in_ready, .key,
    .out_valid, .out_ready, .slot, .placed, .already_present,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .inserts_in_flight, .fault_count
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned live_size(input logic [SIZE_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_SLOTS) return MAX_SLOTS;
    return raw;
  endfunction

  // Mix of repeated keys, keys that share a home slot, random and edge keys
  function automatic logic [KEY_W-1:0] pick_key(input int unsigned n);
    logic [KEY_W-1:0] k;
    longint unsigned  base;
    int unsigned      r;
    r = $urandom_range(0, 99);
    k = KEY_W'($urandom);
    if (r < 30 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < 60) begin
      base = (k / n) * n + $urandom_range(0, (n < 4) ? n - 1 : 3);
      if (base > KEY_ALL_ONES) base -= n;
      return KEY_W'(base);
    end
    if (r < 90) return k;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return KEY_ALL_ONES;
      2:       return KEY_W'(n);
      default: return KEY_W'(n - 1);
    endcase
  endfunction

  // One register access: setup cycle, then access cycle until pready
  task automatic apb_access(input bit wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one key and hold it until taken
  task automatic send_key(input logic [KEY_W-1:0] k);
    int gap;
    gap = (feed_calm || $urandom_range(0, 1)) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key      <= k;
    do @(posedge clk); while (!in_ready);
    key_pool.push_back(k);
    if (key_pool.size() > 64) void'(key_pool.pop_front());
  endtask

  // Stop feeding and wait until every insert has reported
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (inserts_in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_table_size(input logic [SIZE_W-1:0] raw);
    settle();
    apb_access(1'b1, ADDR_TABLE_SIZE, DATA_W'(raw));
    apb_access(1'b0, ADDR_TABLE_SIZE, '0);
  endtask

  // Result side: random stalls, calm stretches, one long hold
  initial begin : result_sink
    int  stall_left;
    int  keys_taken;
    int  cycles;
    bit  calm;
    bit  held;
    out_ready  = 1'b0;
    stall_left = 0;
    keys_taken = 0;
    cycles     = 0;
    calm       = 1'b0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      cycles++;
      if (in_valid && in_ready) keys_taken++;
      if (cycles % 128 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!held && keys_taken >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] raw;
    int unsigned       n;
    int                sent;
    int                phase;
    int                phase_items;
    int                r;
    rst       = 1'b1;
    in_valid  = 1'b0;
    key       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    feed_calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset size: zero key, repeats, shared home slot, key extremes
    send_key('0);
    send_key('0);
    send_key(KEY_W'(11));
    send_key(KEY_W'(22));
    send_key(KEY_ALL_ONES);
    send_key(KEY_ALL_ONES);
    send_key(KEY_W'(32'h5555_5555));
    send_key(KEY_W'(32'h2AAA_AAAA));
    send_key(KEY_W'(1));

    // Sizes below two act as two; full slots drive the probe limit
    set_table_size('0);
    send_key(KEY_W'(2));
    send_key(KEY_W'(3));
    send_key('0);
    send_key(KEY_W'(5));
    set_table_size(SIZE_W'(1));
    send_key(KEY_W'(4));
    send_key(KEY_W'(1));

    // Unmapped register write must leave the size alone
    settle();
    apb_access(1'b1, ADDR_UNMAPPED, DATA_W'(5));
    apb_access(1'b0, ADDR_TABLE_SIZE, '0);
    send_key(KEY_W'(7));

    // Size above capacity acts as full capacity; reach the top slot
    set_table_size('1);
    send_key(KEY_W'(MAX_SLOTS + 5));
    send_key(KEY_ALL_ONES);
    send_key(KEY_W'(MAX_SLOTS - 1));
    set_table_size(SIZE_MAX);
    send_key(KEY_W'(MAX_SLOTS - 1));
    send_key(KEY_W'(2 * MAX_SLOTS));

    // Random phases at changing table sizes; table contents carry over
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (phase == 0 || r < 50) raw = SIZE_W'($urandom_range(2, 40));
      else if (r < 58)          raw = SIZE_W'($urandom_range(0, 1));
      else if (r < 63)          raw = SIZE_W'($urandom_range(MAX_SLOTS, 32767));
      else                      raw = SIZE_W'($urandom_range(41, 400));
      set_table_size(raw);
      n           = live_size(raw);
      phase_items = (n >= 4096) ? 4 : (phase == 0) ? 100 : 40;
      feed_calm   = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < phase_items; j++) begin
        send_key(pick_key(n));
        // pause feeding once mid-phase until the block is empty
        if (phase == 2 && j == 20) settle();
      end
      sent += phase_items;
      phase++;
    end

    settle();
    repeat (100) @(posedge clk);
    if (fault_count == 0 && inserts_in_flight == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
